### hw/rtl/instruction_field_register_engine_unit_assert.svh
// assertion macros shared by the field register engine modules
`ifndef INSTRUCTION_FIELD_REGISTER_ENGINE_UNIT_ASSERT_SVH
`define INSTRUCTION_FIELD_REGISTER_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define IFRE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ifre: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define IFRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ifre: next-cycle check failed");

`endif

### hw/rtl/ifre_pkg.sv
// types, codes and constants of the instruction field register engine
package ifre_pkg;

    localparam int NUM_FIELDS_DEF = 26;
    localparam int VAL_W          = 64;
    localparam int LEN_W          = 7;
    localparam int IDX_IN_W       = 5;

    typedef logic [VAL_W-1:0] t_val;
    typedef logic [LEN_W-1:0] t_len;
    typedef logic [IDX_IN_W-1:0] t_idx_in;

    localparam t_len MAX_LEN     = 7'd64;
    localparam t_val ALIGN4_MASK = 64'hFFFF_FFFF_FFFF_FFFC;
    localparam t_val ZERO_SUBST  = 64'd32;

    typedef enum logic [3:0] {
        OP_PUSH   = 4'd0,
        OP_FILL   = 4'd1,
        OP_Z32    = 4'd2,
        OP_SEXT   = 4'd3,
        OP_BEGIN  = 4'd4,
        OP_APPEND = 4'd5,
        OP_STORE  = 4'd6,
        OP_XOR    = 4'd7,
        OP_NOT    = 4'd8,
        OP_MODIMM = 4'd9,
        OP_COND   = 4'd10,
        OP_IT     = 4'd11,
        OP_ALIGN4 = 4'd12,
        OP_NEG    = 4'd13,
        OP_ADD    = 4'd14,
        OP_READ   = 4'd15
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // everything the datapath hands back for one transaction
    typedef struct packed {
        t_val        value;
        t_len        length;
        t_val        conc_val;
        t_len        conc_len;
        logic        cond_valid;
        logic [7:0]  cond;
        logic        it_valid;
        logic [7:0]  it_cond;
        logic [7:0]  it_mask;
    } t_alu_res;

endpackage

### hw/rtl/ifre_file.sv
// field file: value and length memories, two registered read ports, one write port
`include "instruction_field_register_engine_unit_assert.svh"

module ifre_file
    import ifre_pkg::*;
#(
    parameter int NUM_FIELDS = NUM_FIELDS_DEF,
    localparam int AW = $clog2(NUM_FIELDS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output t_val          o_rval_a,
    output t_len          o_rlen_a,
    output t_val          o_rval_b,
    output t_len          o_rlen_b,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_val          i_wval,
    input  t_len          i_wlen
);

    t_val r_val_mem [NUM_FIELDS];
    t_len r_len_mem [NUM_FIELDS];
    logic [NUM_FIELDS-1:0] r_vld;

    t_val r_rval_a;
    t_len r_rlen_a;
    logic r_rvld_a;
    t_val r_rval_b;
    t_len r_rlen_b;
    logic r_rvld_b;

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_val_mem[i_waddr] <= i_wval;
            r_len_mem[i_waddr] <= i_wlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rval_a <= r_val_mem[i_raddr_a];
            r_rlen_a <= r_len_mem[i_raddr_a];
            r_rvld_a <= r_vld[i_raddr_a];
            r_rval_b <= r_val_mem[i_raddr_b];
            r_rlen_b <= r_len_mem[i_raddr_b];
            r_rvld_b <= r_vld[i_raddr_b];
        end
    end

    assign o_rval_a = r_rvld_a ? r_rval_a : '0;
    assign o_rlen_a = r_rvld_a ? r_rlen_a : '0;
    assign o_rval_b = r_rvld_b ? r_rval_b : '0;
    assign o_rlen_b = r_rvld_b ? r_rlen_b : '0;

    `IFRE_ASSERT_NOW(a_wr_in_range, i_clk, i_rst_n, i_we, 32'(i_waddr) < NUM_FIELDS)
    `IFRE_ASSERT_NOW(a_no_rd_on_wr, i_clk, i_rst_n, i_we, !i_rd_en)

endmodule

### hw/rtl/ifre_alu.sv
// operation datapath: computes the new field and accumulator contents
module ifre_alu
    import ifre_pkg::*;
(
    input  t_op      i_op,
    input  logic     i_bit_req,
    input  t_val     i_addend,
    input  t_val     i_val,
    input  t_len     i_len,
    input  t_val     i_sval,
    input  t_len     i_slen,
    input  t_val     i_cval,
    input  t_len     i_clen,
    output t_alu_res o_res
);

    function automatic t_len sat_len(input t_len a, input t_len b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, MAX_LEN}) ? MAX_LEN : s[LEN_W-1:0];
    endfunction

    // thumb-2 modified immediate from the low 12 bits
    function automatic t_val expand_imm(input t_val v);
        logic [7:0]  c;
        logic [4:0]  kind;
        logic [5:0]  sh;
        logic [31:0] w;
        c    = v[7:0];
        kind = v[11:7];
        sh   = 6'd32 - {1'b0, kind};
        case (kind[4:1])
            4'd0:    w = {24'd0, c};
            4'd1:    w = {8'd0, c, 8'd0, c};
            4'd2:    w = {c, 8'd0, c, 8'd0};
            4'd3:    w = {c, c, c, c};
            default: w = {24'd0, c | 8'h80} << sh;
        endcase
        return {32'd0, w};
    endfunction

    logic [5:0] w_sext_top;
    logic       w_sext_hit;

    assign w_sext_top = 6'(i_len - 7'd1);
    assign w_sext_hit = (i_len != '0) && (i_len < MAX_LEN) && i_val[w_sext_top];

    always_comb begin
        o_res            = '0;
        o_res.value      = i_val;
        o_res.length     = i_len;
        o_res.conc_val   = i_cval;
        o_res.conc_len   = i_clen;
        unique case (i_op)
            OP_PUSH: begin
                o_res.value  = {i_val[VAL_W-2:0], i_bit_req};
                o_res.length = sat_len(i_len, 7'd1);
            end
            OP_FILL:   o_res.value = {VAL_W{i_bit_req}};
            OP_Z32: begin
                if (i_val == '0) o_res.value = ZERO_SUBST;
            end
            OP_SEXT: begin
                if (w_sext_hit) o_res.value = i_val - (64'd1 << i_len[5:0]);
            end
            OP_BEGIN: begin
                o_res.conc_val = '0;
                o_res.conc_len = '0;
            end
            OP_APPEND: begin
                o_res.conc_val = (i_slen >= MAX_LEN) ? i_sval
                                                     : ((i_cval << i_slen[5:0]) | i_sval);
                o_res.conc_len = sat_len(i_clen, i_slen);
            end
            OP_STORE: begin
                o_res.value  = i_cval;
                o_res.length = i_clen;
            end
            OP_XOR:    o_res.value = i_val ^ i_sval;
            OP_NOT:    o_res.value = i_val ^ 64'd1;
            OP_MODIMM: o_res.value = expand_imm(i_val);
            OP_COND: begin
                o_res.cond_valid = 1'b1;
                o_res.cond       = i_val[7:0];
            end
            OP_IT: begin
                o_res.it_valid = 1'b1;
                o_res.it_cond  = i_val[7:0];
                o_res.it_mask  = i_sval[7:0];
            end
            OP_ALIGN4: o_res.value = i_val & ALIGN4_MASK;
            OP_NEG:    o_res.value = '0 - i_val;
            OP_ADD:    o_res.value = i_val + i_addend;
            OP_READ:   o_res.value = i_val;
            default:   o_res.value = i_val;
        endcase
    end

endmodule

### hw/rtl/instruction_field_register_engine_unit.sv
// top level of the instruction field register engine
//
// A file of NUM_FIELDS instruction fields, each a 64-bit value with a bit
// length of 0 to 64, plus one concatenation accumulator. A transaction is
// taken at a rising edge where start is high and busy is low; it reads the
// dest and src fields, applies the operation in i_op, writes dest back and
// reports dest's new contents. The fields sit in a synchronous memory with a
// registered read, so each transaction spends two cycles: the accept cycle
// launches the read, and in the next cycle (busy high) the result is computed
// and written back. o_valid rises for exactly one cycle right after that, and
// start may be raised again in that same cycle, so one transaction completes
// every two cycles with a latency of two cycles from accept to o_valid. The
// receiver cannot stall: results must be captured in the o_valid cycle. A
// dest or src at or above NUM_FIELDS reads as zero, a write to such a dest is
// dropped and its result reports zero. All fields read as zero after reset
// with no clearing pass; o_cond, o_it_cond and o_it_mask are zero unless their
// valid flag is set.
`include "instruction_field_register_engine_unit_assert.svh"

module instruction_field_register_engine_unit
    import ifre_pkg::*;
#(
    parameter int NUM_FIELDS = NUM_FIELDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_op,
    input  logic [4:0]         i_dest,
    input  logic [4:0]         i_src,
    input  logic               i_bit_req,
    input  logic signed [63:0] i_addend,
    output logic               o_valid,
    output logic signed [63:0] o_value,
    output logic [6:0]         o_length,
    output logic               o_cond_valid,
    output logic [7:0]         o_cond,
    output logic               o_it_valid,
    output logic [7:0]         o_it_cond,
    output logic [7:0]         o_it_mask
);

    localparam int AW = $clog2(NUM_FIELDS);

    // control
    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_exec;

    // transaction held across the read cycle
    t_op           r_op;
    logic [AW-1:0] r_dest_addr;
    logic          r_dest_ok;
    logic          r_src_ok;
    logic          r_bit_req;
    t_val          r_addend;

    logic          w_dest_ok;
    logic          w_src_ok;

    // concatenation accumulator
    t_val r_cval;
    t_len r_clen;

    // field file read data
    t_val w_rval_a;
    t_len w_rlen_a;
    t_val w_rval_b;
    t_len w_rlen_b;

    t_alu_res w_res;

    // result register
    logic       r_out_valid;
    t_val       r_out_val;
    t_len       r_out_len;
    logic       r_out_cv;
    logic [7:0] r_out_cc;
    logic       r_out_iv;
    logic [7:0] r_out_ic;
    logic [7:0] r_out_im;

    assign w_accept = start && !busy;
    assign w_dest_ok = 32'(i_dest) < NUM_FIELDS;
    assign w_src_ok  = 32'(i_src) < NUM_FIELDS;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_EXEC;
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy   = 1'b0;
        w_exec = 1'b0;
        unique case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_EXEC: begin
                busy   = 1'b1;
                w_exec = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= t_op'(i_op);
            r_dest_addr <= AW'(i_dest);
            r_dest_ok   <= w_dest_ok;
            r_src_ok    <= w_src_ok;
            r_bit_req   <= i_bit_req;
            r_addend    <= $unsigned(i_addend);
        end
    end

    // read launched on accept; write back lands before any later read,
    // so no forwarding path is needed
    ifre_file #(
        .NUM_FIELDS (NUM_FIELDS)
    ) u_file (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_raddr_a (AW'(i_dest)),
        .i_raddr_b (AW'(i_src)),
        .o_rval_a  (w_rval_a),
        .o_rlen_a  (w_rlen_a),
        .o_rval_b  (w_rval_b),
        .o_rlen_b  (w_rlen_b),
        .i_we      (w_exec && r_dest_ok),
        .i_waddr   (r_dest_addr),
        .i_wval    (w_res.value),
        .i_wlen    (w_res.length)
    );

    // out-of-range indexes read as an empty field
    ifre_alu u_alu (
        .i_op      (r_op),
        .i_bit_req (r_bit_req),
        .i_addend  (r_addend),
        .i_val     (r_dest_ok ? w_rval_a : '0),
        .i_len     (r_dest_ok ? w_rlen_a : '0),
        .i_sval    (r_src_ok ? w_rval_b : '0),
        .i_slen    (r_src_ok ? w_rlen_b : '0),
        .i_cval    (r_cval),
        .i_clen    (r_clen),
        .o_res     (w_res)
    );

    // accumulator is updated whatever the dest index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cval <= '0;
            r_clen <= '0;
        end else if (w_exec) begin
            r_cval <= w_res.conc_val;
            r_clen <= w_res.conc_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_val <= r_dest_ok ? w_res.value : '0;
            r_out_len <= r_dest_ok ? w_res.length : '0;
            r_out_cv  <= w_res.cond_valid;
            r_out_cc  <= w_res.cond;
            r_out_iv  <= w_res.it_valid;
            r_out_ic  <= w_res.it_cond;
            r_out_im  <= w_res.it_mask;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value      = $signed(r_out_val);
    assign o_length     = r_out_len;
    assign o_cond_valid = r_out_cv;
    assign o_cond       = r_out_cc;
    assign o_it_valid   = r_out_iv;
    assign o_it_cond    = r_out_ic;
    assign o_it_mask    = r_out_im;

    `IFRE_ASSERT_NEXT(a_accept_then_exec, i_clk, i_rst_n, w_accept, busy)
    `IFRE_ASSERT_NEXT(a_exec_then_result, i_clk, i_rst_n, busy, o_valid && !busy)
    `IFRE_ASSERT_NOW(a_result_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `IFRE_ASSERT_NOW(a_cond_zero_unissued, i_clk, i_rst_n, o_valid && !o_cond_valid, o_cond == 8'd0)
    `IFRE_ASSERT_NOW(a_it_zero_unissued, i_clk, i_rst_n, o_valid && !o_it_valid, o_it_mask == 8'd0)

endmodule
